// File: design/palette_dither_mapper_macros.svh
// Assertion macros for the palette dither mapper.
`ifndef PALETTE_DITHER_MAPPER_MACROS_SVH
`define PALETTE_DITHER_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
`define PDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PDM_ASSERT_NOW(lbl, ante, cons, msg)
`define PDM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/pdm_pkg.sv
// Shared constants, types and arithmetic helpers for the palette dither mapper.
package pdm_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int COL_W         = $clog2(MAX_WIDTH);
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int GRID_BITS     = 5;
  localparam int KEY_W         = 3 * GRID_BITS;
  localparam int CELL_COUNT    = 1 << KEY_W;
  localparam int ERR_W         = 13;
  localparam int CACHE_W       = 9;

  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_PAL   = 2'd1;
  localparam logic [1:0] REQ_FRAME = 2'd2;

  localparam logic [2:0] CFG_IMAGE_WIDTH = 3'd0;
  localparam logic [2:0] CFG_ALPHA_THR   = 3'd1;
  localparam logic [2:0] CFG_MATTE       = 3'd2;
  localparam logic [2:0] CFG_PAL_COUNT   = 3'd3;
  localparam logic [2:0] CFG_TRANSP_IDX  = 3'd4;
  localparam logic [2:0] CFG_DITHER      = 3'd5;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [23:0]       rgb;
  } pdm_pal_wr_t;

  typedef struct packed {
    logic        valid;
    logic [23:0] rgb;
  } pdm_lk_req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  index;
    logic [23:0] rgb;
  } pdm_lk_rsp_t;

  // floor(v / 255) for v below 65280
  function automatic logic [7:0] div255(input logic [16:0] v);
    logic [17:0] s;
    s = {1'b0, v} + 18'(v[16:8]) + 18'd1;
    return s[15:8];
  endfunction

  function automatic logic signed [ERR_W-1:0] ext_err(input logic signed [8:0] e);
    return {{(ERR_W-9){e[8]}}, e};
  endfunction

  // a + 5b + 3c in 1/16 units
  function automatic logic signed [ERR_W-1:0] err_mix(input logic signed [8:0] a,
                                                      input logic signed [8:0] b,
                                                      input logic signed [8:0] c);
    logic signed [ERR_W-1:0] xa, xb, xc;
    xa = ext_err(a);
    xb = ext_err(b);
    xc = ext_err(c);
    return xa + xb + (xb <<< 2) + xc + (xc <<< 1);
  endfunction

  function automatic logic [KEY_W-1:0] cell_key(input logic [23:0] rgb);
    return {rgb[23 -: GRID_BITS], rgb[15 -: GRID_BITS], rgb[7 -: GRID_BITS]};
  endfunction

endpackage

// File: design/pdm_ram.sv
// Generic simple dual-port RAM with registered read.
module pdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/pdm_nearest.sv
// Palette store, per-cell nearest cache and sequential palette search.
module pdm_nearest (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pdm_pkg::pdm_pal_wr_t pal_wr,
  input  logic                 clear_start,
  input  pdm_pkg::pdm_lk_req_t lk_req,
  output pdm_pkg::pdm_lk_rsp_t lk_rsp,
  output logic                 busy,
  input  logic [8:0]           palette_count,
  input  logic [8:0]           transparent_index
);

  typedef enum logic [2:0] {N_CLEAR, N_IDLE, N_LOOK, N_SRCH, N_FILL, N_PWAIT} nr_state_t;

  nr_state_t                       st_r;
  logic [pdm_pkg::KEY_W-1:0]       clr_cnt_r;
  logic [pdm_pkg::KEY_W-1:0]       key_r;
  logic [23:0]                     want_r;
  logic [9:0]                      sc_r;
  logic                            p1_v_r;
  logic                            sq_v_r;
  logic [pdm_pkg::PAL_AW-1:0]      p1_i_r;
  logic [pdm_pkg::PAL_AW-1:0]      sq_i_r;
  logic [15:0]                     sq_r [3];
  logic [17:0]                     best_d_r;
  logic [pdm_pkg::PAL_AW-1:0]      best_r;
  logic [7:0]                      idx_r;

  logic [8:0]                      n_eff;
  logic [17:0]                     dsum;
  logic [15:0]                     sq_nxt [3];
  logic [23:0]                     pal_rd;
  logic [pdm_pkg::PAL_AW-1:0]      pal_raddr;
  logic [pdm_pkg::CACHE_W-1:0]     cache_rd;
  logic                            cache_we;
  logic [pdm_pkg::KEY_W-1:0]       cache_waddr;
  logic [pdm_pkg::CACHE_W-1:0]     cache_wdata;

  assign n_eff = (palette_count > 9'(pdm_pkg::PALETTE_DEPTH)) ?
                 9'(pdm_pkg::PALETTE_DEPTH) : palette_count;

  always_comb begin
    logic signed [8:0]  df;
    logic signed [17:0] pr;
    for (int ch = 0; ch < 3; ch++) begin
      df = $signed({1'b0, pal_rd[23-8*ch -: 8]}) - $signed({1'b0, want_r[23-8*ch -: 8]});
      pr = df * df;
      sq_nxt[ch] = pr[15:0];
    end
  end

  assign dsum = 18'(sq_r[0]) + 18'(sq_r[1]) + 18'(sq_r[2]);

  always_comb begin
    case (st_r)
      N_SRCH:  pal_raddr = sc_r[pdm_pkg::PAL_AW-1:0];
      N_LOOK:  pal_raddr = cache_rd[pdm_pkg::PAL_AW-1:0];
      default: pal_raddr = best_r;
    endcase
  end

  assign cache_we    = (st_r == N_CLEAR) || (st_r == N_FILL);
  assign cache_waddr = (st_r == N_CLEAR) ? clr_cnt_r : key_r;
  assign cache_wdata = (st_r == N_CLEAR) ? '0 : {1'b1, best_r};

  pdm_ram #(.WIDTH(24), .DEPTH(pdm_pkg::PALETTE_DEPTH)) u_pal (
    .clk   (clk),
    .we    (pal_wr.en),
    .waddr (pal_wr.addr),
    .wdata (pal_wr.rgb),
    .re    (1'b1),
    .raddr (pal_raddr),
    .rdata (pal_rd)
  );

  pdm_ram #(.WIDTH(pdm_pkg::CACHE_W), .DEPTH(pdm_pkg::CELL_COUNT)) u_cache (
    .clk   (clk),
    .we    (cache_we),
    .waddr (cache_waddr),
    .wdata (cache_wdata),
    .re    (lk_req.valid),
    .raddr (pdm_pkg::cell_key(lk_req.rgb)),
    .rdata (cache_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= N_CLEAR;
      clr_cnt_r <= '0;
      p1_v_r    <= 1'b0;
      sq_v_r    <= 1'b0;
    end else begin
      case (st_r)
        N_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (&clr_cnt_r) begin
            st_r <= N_IDLE;
          end
        end
        N_IDLE: begin
          if (clear_start) begin
            clr_cnt_r <= '0;
            st_r      <= N_CLEAR;
          end else if (lk_req.valid) begin
            key_r  <= pdm_pkg::cell_key(lk_req.rgb);
            want_r <= lk_req.rgb;
            st_r   <= N_LOOK;
          end
        end
        N_LOOK: begin
          if (cache_rd[pdm_pkg::CACHE_W-1]) begin
            idx_r <= cache_rd[7:0];
            st_r  <= N_PWAIT;
          end else begin
            sc_r     <= '0;
            p1_v_r   <= 1'b0;
            sq_v_r   <= 1'b0;
            best_d_r <= '1;
            best_r   <= '0;
            st_r     <= N_SRCH;
          end
        end
        N_SRCH: begin
          sc_r   <= sc_r + 1'b1;
          p1_v_r <= (sc_r < {1'b0, n_eff}) && (sc_r[8:0] != transparent_index);
          p1_i_r <= sc_r[pdm_pkg::PAL_AW-1:0];
          sq_v_r <= p1_v_r;
          sq_i_r <= p1_i_r;
          for (int ch = 0; ch < 3; ch++) begin
            sq_r[ch] <= sq_nxt[ch];
          end
          if (sq_v_r && (dsum < best_d_r)) begin
            best_d_r <= dsum;
            best_r   <= sq_i_r;
          end
          if (sc_r == ({1'b0, n_eff} + 10'd1)) begin
            st_r <= N_FILL;
          end
        end
        N_FILL: begin
          idx_r <= 8'(best_r);
          st_r  <= N_PWAIT;
        end
        N_PWAIT: begin
          st_r <= N_IDLE;
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign busy         = (st_r != N_IDLE);
  assign lk_rsp.done  = (st_r == N_PWAIT);
  assign lk_rsp.index = idx_r;
  assign lk_rsp.rgb   = pal_rd;

endmodule

// File: design/palette_dither_mapper.sv
// Top level: compositing, error diffusion line store and pixel sequencing.
//
// channel | handshake           | payload
// in      | in_valid/in_ready   | req_type, red, green, blue, alpha, entry_index
// out     | out_valid/out_ready | palette_index, is_transparent, row_end
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A pixel passes T_MIX, T_WANT, T_LOOK, T_ERR and T_DONE; a transparent one skips T_LOOK;
// a cell miss adds a search over palette_count entries (capped at 256) in pdm_nearest;
// a row end adds T_END1 and T_END2. Palette writes and other requests stay in T_IDLE.
// The lookup in T_LOOK waits on the cache and palette reads of pdm_nearest.
// Reset and each start of frame clear all 32768 cache cells; in_ready is low then.
// A result waits in the output register; the next request is taken meanwhile.
`include "palette_dither_mapper_macros.svh"
module palette_dither_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_palette_index,
  output logic        out_is_transparent,
  output logic        out_row_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE, T_MIX, T_WANT, T_LOOK, T_ERR, T_END1, T_END2, T_DONE
  } top_state_t;

  localparam int EW = pdm_pkg::ERR_W;

  top_state_t                  st_r;
  logic [12:0]                 image_width_r;
  logic [8:0]                  alpha_thr_r;
  logic [23:0]                 matte_r;
  logic [8:0]                  pal_count_r;
  logic [8:0]                  transp_idx_r;
  logic                        dither_r;

  logic [pdm_pkg::COL_W-1:0]   col_r;
  logic [pdm_pkg::COL_W:0]     prev_len_r;
  logic [23:0]                 px_r;
  logic [7:0]                  alpha_r;
  logic                        transp_r;
  logic                        last_r;
  logic [16:0]                 v_r [3];
  logic signed [EW:0]          cur_r [3];
  logic [23:0]                 want_r;
  logic signed [8:0]           err_r [3];
  logic signed [8:0]           e1_r [3];
  logic signed [8:0]           e2_r [3];
  logic signed [EW-1:0]        carry_r [3];
  logic [7:0]                  idx_r;
  logic                        out_valid_r;
  logic [7:0]                  out_idx_r;
  logic                        out_transp_r;
  logic                        out_last_r;

  logic                        in_acc;
  logic [12:0]                 width_eff;
  logic                        last_now;
  logic                        transp_now;
  logic [23:0]                 want_nxt;
  logic                        nr_busy;
  pdm_pkg::pdm_pal_wr_t        pal_wr;
  pdm_pkg::pdm_lk_req_t        lk_req;
  pdm_pkg::pdm_lk_rsp_t        lk_rsp;
  logic                        erow_we;
  logic [pdm_pkg::COL_W-1:0]   erow_waddr;
  logic [3*EW-1:0]             erow_wdata;
  logic [3*EW-1:0]             erow_rd;

  assign in_ready  = (st_r == T_IDLE) && !nr_busy;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign width_eff  = (image_width_r == 13'd0) ? 13'd1 :
                      ((image_width_r > 13'(pdm_pkg::MAX_WIDTH)) ?
                       13'(pdm_pkg::MAX_WIDTH) : image_width_r);
  assign last_now   = ({1'b0, col_r} + 13'd1) >= width_eff;
  assign transp_now = (alpha_thr_r != 9'd0) && ({1'b0, in_alpha} < alpha_thr_r);

  assign pal_wr.en   = in_acc && (in_req_type == pdm_pkg::REQ_PAL);
  assign pal_wr.addr = in_entry_index;
  assign pal_wr.rgb  = {in_red, in_green, in_blue};

  always_comb begin
    logic [7:0]         flat;
    logic signed [EW:0] t;
    logic [11:0]        tc;
    logic [12:0]        rnd;
    for (int ch = 0; ch < 3; ch++) begin
      flat = pdm_pkg::div255(v_r[ch]);
      t    = $signed({2'b00, flat, 4'b0000}) + cur_r[ch];
      if (t < 0) begin
        tc = 12'd0;
      end else if (t > $signed(14'd4080)) begin
        tc = 12'd4080;
      end else begin
        tc = t[11:0];
      end
      rnd = {1'b0, tc} + 13'd8;
      want_nxt[23-8*ch -: 8] = dither_r ? rnd[11:4] : flat;
    end
  end

  assign lk_req.valid = (st_r == T_WANT) && !transp_r;
  assign lk_req.rgb   = want_nxt;

  pdm_nearest u_nearest (
    .clk               (clk),
    .rst_n             (rst_n),
    .pal_wr            (pal_wr),
    .clear_start       (in_acc && (in_req_type == pdm_pkg::REQ_FRAME)),
    .lk_req            (lk_req),
    .lk_rsp            (lk_rsp),
    .busy              (nr_busy),
    .palette_count     (pal_count_r),
    .transparent_index (transp_idx_r)
  );

  always_comb begin
    erow_we    = 1'b0;
    erow_waddr = col_r;
    erow_wdata = '0;
    case (st_r)
      T_ERR: begin
        erow_we    = (col_r != '0);
        erow_waddr = col_r - 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
          erow_wdata[3*EW-1-EW*ch -: EW] = pdm_pkg::err_mix(e2_r[ch], e1_r[ch], err_r[ch]);
        end
      end
      T_END1: begin
        erow_we    = 1'b1;
        erow_waddr = col_r;
        for (int ch = 0; ch < 3; ch++) begin
          erow_wdata[3*EW-1-EW*ch -: EW] = pdm_pkg::err_mix(e2_r[ch], e1_r[ch], 9'sd0);
        end
      end
      T_END2: begin
        erow_we    = !(&col_r);
        erow_waddr = col_r + 1'b1;
        for (int ch = 0; ch < 3; ch++) begin
          erow_wdata[3*EW-1-EW*ch -: EW] = pdm_pkg::err_mix(e1_r[ch], 9'sd0, 9'sd0);
        end
      end
      default: erow_we = 1'b0;
    endcase
  end

  pdm_ram #(.WIDTH(3*EW), .DEPTH(pdm_pkg::MAX_WIDTH)) u_erow (
    .clk   (clk),
    .we    (erow_we),
    .waddr (erow_waddr),
    .wdata (erow_wdata),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (erow_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= T_IDLE;
      image_width_r <= 13'd1;
      alpha_thr_r   <= 9'd0;
      matte_r       <= 24'd0;
      pal_count_r   <= 9'd1;
      transp_idx_r  <= 9'd256;
      dither_r      <= 1'b1;
      col_r         <= '0;
      prev_len_r    <= '0;
      out_valid_r   <= 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
        e1_r[ch]    <= '0;
        e2_r[ch]    <= '0;
        carry_r[ch] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pdm_pkg::CFG_IMAGE_WIDTH: image_width_r <= cfg_data[12:0];
          pdm_pkg::CFG_ALPHA_THR:   alpha_thr_r   <= cfg_data[8:0];
          pdm_pkg::CFG_MATTE:       matte_r       <= cfg_data;
          pdm_pkg::CFG_PAL_COUNT:   pal_count_r   <= cfg_data[8:0];
          pdm_pkg::CFG_TRANSP_IDX:  transp_idx_r  <= cfg_data[8:0];
          pdm_pkg::CFG_DITHER:      dither_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (st_r != T_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        T_IDLE: begin
          if (in_acc) begin
            case (in_req_type)
              pdm_pkg::REQ_PIXEL: begin
                px_r     <= {in_red, in_green, in_blue};
                alpha_r  <= in_alpha;
                transp_r <= transp_now;
                last_r   <= last_now;
                st_r     <= T_MIX;
              end
              pdm_pkg::REQ_FRAME: begin
                col_r      <= '0;
                prev_len_r <= '0;
                for (int ch = 0; ch < 3; ch++) begin
                  e1_r[ch]    <= '0;
                  e2_r[ch]    <= '0;
                  carry_r[ch] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        T_MIX: begin
          for (int ch = 0; ch < 3; ch++) begin
            v_r[ch] <= 17'(px_r[23-8*ch -: 8] * alpha_r)
                     + 17'(matte_r[23-8*ch -: 8] * (8'd255 - alpha_r)) + 17'd127;
            cur_r[ch] <= ({1'b0, col_r} < prev_len_r) ?
                         ($signed({erow_rd[3*EW-1-EW*ch], erow_rd[3*EW-1-EW*ch -: EW]})
                          + $signed({carry_r[ch][EW-1], carry_r[ch]})) :
                         $signed({carry_r[ch][EW-1], carry_r[ch]});
          end
          st_r <= T_WANT;
        end
        T_WANT: begin
          want_r <= want_nxt;
          if (transp_r) begin
            idx_r <= transp_idx_r[7:0];
            for (int ch = 0; ch < 3; ch++) begin
              err_r[ch] <= '0;
            end
            st_r <= T_ERR;
          end else begin
            st_r <= T_LOOK;
          end
        end
        T_LOOK: begin
          if (lk_rsp.done) begin
            idx_r <= lk_rsp.index;
            for (int ch = 0; ch < 3; ch++) begin
              err_r[ch] <= dither_r ?
                           ($signed({1'b0, want_r[23-8*ch -: 8]})
                            - $signed({1'b0, lk_rsp.rgb[23-8*ch -: 8]})) : 9'sd0;
            end
            st_r <= T_ERR;
          end
        end
        T_ERR: begin
          for (int ch = 0; ch < 3; ch++) begin
            e2_r[ch]    <= e1_r[ch];
            e1_r[ch]    <= err_r[ch];
            carry_r[ch] <= (pdm_pkg::ext_err(err_r[ch]) <<< 3) - pdm_pkg::ext_err(err_r[ch]);
          end
          if (last_r) begin
            st_r <= T_END1;
          end else begin
            col_r <= col_r + 1'b1;
            st_r  <= T_DONE;
          end
        end
        T_END1: begin
          st_r <= T_END2;
        end
        T_END2: begin
          prev_len_r <= {1'b0, col_r} + 13'd2;
          col_r      <= '0;
          for (int ch = 0; ch < 3; ch++) begin
            e1_r[ch]    <= '0;
            e2_r[ch]    <= '0;
            carry_r[ch] <= '0;
          end
          st_r <= T_DONE;
        end
        T_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_idx_r    <= idx_r;
            out_transp_r <= transp_r;
            out_last_r   <= last_r;
            st_r         <= T_IDLE;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_palette_index  = out_idx_r;
  assign out_is_transparent = out_transp_r;
  assign out_row_end        = out_last_r;

  `PDM_ASSERT_NOW(a_rsp_in_look, lk_rsp.done, st_r == T_LOOK, "lookup response outside lookup")
  `PDM_ASSERT_NEXT(a_pixel_starts, in_acc && (in_req_type == pdm_pkg::REQ_PIXEL), st_r == T_MIX, "pixel request did not start")
  `PDM_ASSERT_NEXT(a_row_wraps, st_r == T_END2, col_r == '0, "column not cleared at row end")

endmodule

// File: dv/palette_dither_mapper_tb.sv
// Testbench for palette_dither_mapper: directed table plus random pixel streams against a predictor.
`timescale 1ns / 1ps
module palette_dither_mapper_tb;

  localparam logic [1:0] REQ_NOOP = 2'd3;
  localparam int DRAIN_CYCLES = 300;
  localparam int STALL_LIMIT  = 120000;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [7:0] index;
    logic       transp;
    logic       row_end;
  } map_result_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  cfg_idx;
    logic [23:0] cfg_val;
    logic [1:0]  req;
    logic [7:0]  r, g, b, a, slot;
    bit          typed;
    map_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0, in_entry_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_palette_index;
  logic        out_is_transparent;
  logic        out_row_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  palette_dither_mapper i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of block state
  logic [12:0] m_width;
  logic [8:0]  m_thr, m_count, m_tidx;
  logic [23:0] m_matte;
  logic        m_dither;
  logic [23:0] pal_mirror [pdm_pkg::PALETTE_DEPTH];
  logic [8:0]  cell_cache [pdm_pkg::CELL_COUNT];
  int          diff_rows [2][pdm_pkg::MAX_WIDTH+2][3];
  int          bank, column;

  map_result_t expected_q[$];
  bit          typed_now = 1'b0;
  map_result_t typed_res;
  int          errors = 0;
  int          n_pixels = 0, n_results = 0, n_transp = 0, n_rows = 0, n_cfg = 0;
  bit          no_idle = 1'b0;
  bit          hold_out = 1'b0;

  task automatic report(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void clear_frame();
    foreach (cell_cache[i]) cell_cache[i] = '0;
    foreach (diff_rows[b, s, c]) diff_rows[b][s][c] = 0;
    bank = 0;
    column = 0;
  endfunction

  function automatic int chan(input logic [23:0] rgb, input int c);
    return int'(rgb[16-8*c +: 8]);
  endfunction

  function automatic int nearest_entry(input int want[3]);
    int n, best, best_d, d, dd;
    logic [pdm_pkg::KEY_W-1:0] key;
    key = {want[0][7 -: pdm_pkg::GRID_BITS], want[1][7 -: pdm_pkg::GRID_BITS],
           want[2][7 -: pdm_pkg::GRID_BITS]};
    if (!cell_cache[key][8]) begin
      n = (m_count > pdm_pkg::PALETTE_DEPTH) ? pdm_pkg::PALETTE_DEPTH : int'(m_count);
      best = 0;
      best_d = -1;
      for (int i = 0; i < n; i++) begin
        if (i == int'(m_tidx)) continue;
        d = 0;
        for (int c = 0; c < 3; c++) begin
          dd = chan(pal_mirror[i], c) - want[c];
          d += dd * dd;
        end
        if (best_d < 0 || d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      cell_cache[key] = {1'b1, 8'(best)};
    end
    return int'(cell_cache[key][7:0]);
  endfunction

  function automatic bit map_request(input logic [1:0] req, input logic [7:0] r, g, b, a,
                                     input logic [7:0] slot, output map_result_t res);
    int width, idx, e, t, er, nb;
    int flat[3], want[3];
    bit last, transp;
    res = '0;
    if (req == pdm_pkg::REQ_PAL) begin
      pal_mirror[slot] = {r, g, b};
      return 1'b0;
    end
    if (req == pdm_pkg::REQ_FRAME) begin
      clear_frame();
      return 1'b0;
    end
    if (req != pdm_pkg::REQ_PIXEL) return 1'b0;
    width = (m_width == 0) ? 1 : int'(m_width);
    if (width > pdm_pkg::MAX_WIDTH) width = pdm_pkg::MAX_WIDTH;
    last = (column + 1 >= width);
    transp = (m_thr != 0) && (int'(a) < int'(m_thr));
    if (transp) begin
      idx = int'(m_tidx[7:0]);
    end else begin
      flat[0] = (int'(r) * int'(a) + chan(m_matte, 0) * (255 - int'(a)) + 127) / 255;
      flat[1] = (int'(g) * int'(a) + chan(m_matte, 1) * (255 - int'(a)) + 127) / 255;
      flat[2] = (int'(b) * int'(a) + chan(m_matte, 2) * (255 - int'(a)) + 127) / 255;
      if (m_dither) begin
        e = column + 1;
        nb = bank ^ 1;
        for (int c = 0; c < 3; c++) begin
          t = flat[c] * 16 + diff_rows[bank][e][c];
          if (t < 0) t = 0;
          if (t > 4080) t = 4080;
          want[c] = (t + 8) >> 4;
        end
        idx = nearest_entry(want);
        for (int c = 0; c < 3; c++) begin
          er = want[c] - chan(pal_mirror[idx], c);
          diff_rows[bank][e+1][c] += 7 * er;
          diff_rows[nb][e-1][c]   += 3 * er;
          diff_rows[nb][e][c]     += 5 * er;
          diff_rows[nb][e+1][c]   += er;
        end
      end else begin
        idx = nearest_entry(flat);
      end
    end
    if (last) begin
      column = 0;
      bank ^= 1;
      for (int s = 0; s < pdm_pkg::MAX_WIDTH + 2; s++)
        for (int c = 0; c < 3; c++) diff_rows[bank^1][s][c] = 0;
    end else begin
      column++;
    end
    res.index = 8'(idx);
    res.transp = transp;
    res.row_end = last;
    return 1'b1;
  endfunction

  // request accepted: predict
  always @(posedge clk) begin
    map_result_t res;
    if (rst_n && in_valid && in_ready) begin
      if (map_request(in_req_type, in_red, in_green, in_blue, in_alpha, in_entry_index, res)) begin
        n_pixels++;
        expected_q = {expected_q, (typed_now ? typed_res : res)};
      end
    end
  end

  // result check
  always @(posedge clk) begin
    map_result_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_palette_index, out_is_transparent, out_row_end};
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result idx=%0d", got.index));
      end else begin
        exp_r = expected_q.pop_front();
        n_results++;
        if (got.transp) n_transp++;
        if (got.row_end) n_rows++;
        if (got.index !== exp_r.index)
          report($sformatf("palette_index %0d, want %0d", got.index, exp_r.index));
        if (got.transp !== exp_r.transp)
          report($sformatf("is_transparent %0b, want %0b", got.transp, exp_r.transp));
        if (got.row_end !== exp_r.row_end)
          report($sformatf("row_end %0b, want %0b", got.row_end, exp_r.row_end));
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (hold_out) begin
      out_ready = 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_out = 1'b0;
    end
    out_ready = no_idle || ($urandom_range(99) >= 9);
  end

  // watchdog
  int stall_cnt = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    drain();
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pdm_pkg::CFG_IMAGE_WIDTH: m_width  = val[12:0];
      pdm_pkg::CFG_ALPHA_THR:   m_thr    = val[8:0];
      pdm_pkg::CFG_MATTE:       m_matte  = val;
      pdm_pkg::CFG_PAL_COUNT:   m_count  = val[8:0];
      pdm_pkg::CFG_TRANSP_IDX:  m_tidx   = val[8:0];
      pdm_pkg::CFG_DITHER:      m_dither = val[0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send(input logic [1:0] req, input logic [7:0] r, g, b, a, slot,
                      input bit typed, input map_result_t want);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_req_type = req;
    in_red = r;
    in_green = g;
    in_blue = b;
    in_alpha = a;
    in_entry_index = slot;
    typed_now = typed;
    typed_res = want;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [23:0] val);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = val;
    return s;
  endfunction

  function automatic stim_row_t px_row(input logic [1:0] req, input logic [7:0] r, g, b, a,
                                       input logic [7:0] slot, input bit typed,
                                       input logic [7:0] idx, input logic tr, re);
    stim_row_t s;
    s = '{default: '0};
    s.req = req;
    s.r = r; s.g = g; s.b = b; s.a = a;
    s.slot = slot;
    s.typed = typed;
    s.want = '{idx, tr, re};
    return s;
  endfunction

  task automatic random_pixel(input bit well_formed);
    logic [7:0] a;
    int pick;
    pick = $urandom_range(99);
    a = ($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF;
    if (well_formed || pick < 80)
      send(pdm_pkg::REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), a, 8'($urandom),
           0, '0);
    else if (pick < 95)
      send(pdm_pkg::REQ_PAL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           8'($urandom), 0, '0);
    else
      send(REQ_NOOP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
           0, '0);
  endtask

  stim_row_t dir_table[$];

  function automatic void add_row(input stim_row_t row);
    dir_table = {dir_table, row};
  endfunction

  initial begin
    int widths[6] = '{2, 5, 13, 1, 7, 3};
    int per_phase;
    m_width = 13'd1;
    m_thr = 9'd0;
    m_matte = 24'd0;
    m_count = 9'd1;
    m_tidx = 9'd256;
    m_dither = 1'b1;
    foreach (pal_mirror[i]) pal_mirror[i] = '0;
    clear_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // load every palette slot so no search reads an empty entry
    send(pdm_pkg::REQ_PAL, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 0, '0);
    for (int i = 1; i < pdm_pkg::PALETTE_DEPTH; i++)
      send(pdm_pkg::REQ_PAL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'(i),
           0, '0);

    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1, 8'd0, 0, 1));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1, 8'd0, 0, 1));
    add_row(px_row(REQ_NOOP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, '0, 0, 0));
    add_row(cfg_row(pdm_pkg::CFG_ALPHA_THR, 24'd256));
    add_row(cfg_row(pdm_pkg::CFG_TRANSP_IDX, 24'd5));
    add_row(cfg_row(pdm_pkg::CFG_IMAGE_WIDTH, 24'd3));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 1, 8'd5, 1, 0));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1, 8'd5, 1, 0));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 1, 8'd5, 1, 1));
    add_row(cfg_row(pdm_pkg::CFG_TRANSP_IDX, 24'd256));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h12, 8'h34, 8'h56, 8'h7F, 8'h00, 1, 8'd0, 1, 0));
    add_row(cfg_row(pdm_pkg::CFG_ALPHA_THR, 24'd0));
    add_row(cfg_row(pdm_pkg::CFG_PAL_COUNT, 24'd256));
    add_row(px_row(pdm_pkg::REQ_FRAME, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, '0, 0, 0));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 0, '0, 0, 0));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h00, 0, '0, 0, 0));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 0, '0, 0, 0));
    add_row(px_row(pdm_pkg::REQ_PAL, 8'hAA, 8'h55, 8'h0F, 8'h00, 8'd7, 0, '0, 0, 0));
    add_row(cfg_row(pdm_pkg::CFG_DITHER, 24'd0));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'hAA, 8'h55, 8'h0F, 8'hFF, 8'h00, 0, '0, 0, 0));
    add_row(cfg_row(pdm_pkg::CFG_MATTE, 24'hFFFFFF));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, '0, 0, 0));
    add_row(cfg_row(pdm_pkg::CFG_IMAGE_WIDTH, 24'd8191));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h40, 8'hC0, 8'h20, 8'hFF, 8'h00, 0, '0, 0, 0));
    add_row(cfg_row(pdm_pkg::CFG_IMAGE_WIDTH, 24'd1));
    add_row(px_row(pdm_pkg::REQ_PIXEL, 8'h01, 8'hFE, 8'h7F, 8'hFF, 8'h00, 0, '0, 0, 0));
    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        stop_sending();
        write_reg(dir_table[i].cfg_idx, dir_table[i].cfg_val);
      end else begin
        send(dir_table[i].req, dir_table[i].r, dir_table[i].g, dir_table[i].b,
             dir_table[i].a, dir_table[i].slot, dir_table[i].typed, dir_table[i].want);
      end
    end

    // random phases
    per_phase = 200;
    for (int ph = 0; ph < 6; ph++) begin
      stop_sending();
      write_reg(pdm_pkg::CFG_IMAGE_WIDTH, 24'(widths[ph]));
      write_reg(pdm_pkg::CFG_ALPHA_THR, (ph == 1) ? 24'd256 : 24'($urandom_range(256)));
      write_reg(pdm_pkg::CFG_MATTE, 24'($urandom));
      write_reg(pdm_pkg::CFG_PAL_COUNT, (ph == 3) ? 24'd1 : 24'($urandom_range(256, 1)));
      write_reg(pdm_pkg::CFG_TRANSP_IDX, (ph == 2) ? 24'd0 : 24'($urandom_range(256)));
      write_reg(pdm_pkg::CFG_DITHER, 24'(ph % 2 == 0));
      if (ph != 4) send(pdm_pkg::REQ_FRAME, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), 0, '0);
      no_idle = (ph == 5);
      for (int k = 0; k < per_phase; k++) begin
        if (ph == 1 && k == 20) hold_out = 1'b1;
        if (ph == 2 && k == 100) begin
          stop_sending();
          while (expected_q.size() != 0) @(posedge clk);
        end
        random_pixel(k < 50 ? 1'b0 : ($urandom_range(9) != 0));
      end
      no_idle = 1'b0;
    end
    stop_sending();

    drain();
    $display("covered %0d pixels, %0d results (%0d transparent, %0d row ends), %0d reg writes",
             n_pixels, n_results, n_transp, n_rows, n_cfg);
    $display("widths, thresholds, palette sizes and dither modes varied over 6 random phases");
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/pdm_pkg.sv
design/pdm_ram.sv
design/pdm_nearest.sv
design/palette_dither_mapper.sv
dv/palette_dither_mapper_tb.sv
